// ----- hw/rtl/rcd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcd_pkg: shared types and constants of the remote-control frame decoder
// Transaction payloads, request and register codes, reset values and widths.
// ----------------------------------------------------------------------------
package rcd_pkg;

  // Receive buffer length: position wraps here (range 18..63)
  localparam int BUF_LEN_DEF = 36;

  // Byte position counter width, fixed by the 6-bit frame length register
  localparam int POS_W = 6;

  // Bytes kept for decoding; bytes beyond these are counted only
  localparam int STORE_LEN = 16;
  localparam int STORE_AW  = 4;

  // Link-loss counter
  localparam int LOSS_W = 4;
  localparam logic [LOSS_W-1:0] LOSS_MAX = 4'd15;

  // Key mask bits of the reboot combination
  localparam int KEY_SHIFT_BIT = 4;
  localparam int KEY_CTRL_BIT  = 5;
  localparam int KEY_B_BIT     = 15;

  // Request codes
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_IDLE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_SW  = 2'd2;

  // Configuration reset values
  localparam logic [5:0]  FRAME_LEN_RST  = 6'd18;
  localparam logic [10:0] CENTER_RST     = 11'd1024;
  localparam logic [1:0]  OFFLINE_SW_RST = 2'd0;

  typedef struct packed {
    logic [5:0]  frame_length;
    logic [10:0] center_value;
    logic [1:0]  offline_switch;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  // Decoded frame state held between frames
  typedef struct packed {
    logic [10:0]        stick_ch0;
    logic [10:0]        stick_ch1;
    logic [10:0]        stick_ch2;
    logic [10:0]        stick_ch3;
    logic [1:0]         switch_left;
    logic [1:0]         switch_right;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_mask;
  } dec_t;

  typedef struct packed {
    logic [10:0]        stick_ch0;
    logic [10:0]        stick_ch1;
    logic [10:0]        stick_ch2;
    logic [10:0]        stick_ch3;
    logic [1:0]         switch_left;
    logic [1:0]         switch_right;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_mask;
    logic               reboot_request;
  } out_item_t;

endpackage

// ----- hw/rtl/rcd_decode.sv -----
// ----------------------------------------------------------------------------
// rcd_decode: frame store, position and link-loss tracking, frame unpacking
// Updates state on each accepted transaction and presents the resulting item.
// ----------------------------------------------------------------------------
module rcd_decode #(
  parameter int BUF_LEN = rcd_pkg::BUF_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  rcd_pkg::in_item_t  item,
  input  rcd_pkg::cfg_t      cfg,
  output rcd_pkg::out_item_t result
);
  import rcd_pkg::*;

  logic [7:0]        frame_bytes_r [STORE_LEN];
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LOSS_W-1:0] loss_r, loss_nxt;
  dec_t              dec_r, dec_nxt, frame_dec;
  logic              store_en;

  // Unpack the stored bytes; all reads at fixed places
  always_comb begin
    frame_dec.stick_ch0     = {frame_bytes_r[1][2:0], frame_bytes_r[0]};
    frame_dec.stick_ch1     = {frame_bytes_r[2][5:0], frame_bytes_r[1][7:3]};
    frame_dec.stick_ch2     = {frame_bytes_r[4][0], frame_bytes_r[3],
                               frame_bytes_r[2][7:6]};
    frame_dec.stick_ch3     = {frame_bytes_r[5][3:0], frame_bytes_r[4][7:1]};
    frame_dec.switch_left   = frame_bytes_r[5][7:6];
    frame_dec.switch_right  = frame_bytes_r[5][5:4];
    frame_dec.mouse_x       = {frame_bytes_r[7], frame_bytes_r[6]};
    frame_dec.mouse_y       = {frame_bytes_r[9], frame_bytes_r[8]};
    frame_dec.mouse_z       = {frame_bytes_r[11], frame_bytes_r[10]};
    frame_dec.mouse_buttons = {frame_bytes_r[13], frame_bytes_r[12]};
    frame_dec.key_mask      = {frame_bytes_r[15], frame_bytes_r[14]};
  end

  always_comb begin
    pos_nxt  = pos_r;
    loss_nxt = loss_r;
    dec_nxt  = dec_r;
    store_en = 1'b0;
    if (accept) begin
      unique case (item.req_type)
        REQ_BYTE: begin
          store_en = (pos_r < POS_W'(STORE_LEN));
          pos_nxt  = (pos_r == POS_W'(BUF_LEN - 1)) ? '0 : pos_r + 1'b1;
        end
        REQ_IDLE: begin
          loss_nxt = '0;
          pos_nxt  = '0;
          if (pos_r == cfg.frame_length) begin
            dec_nxt = frame_dec;
          end
        end
        REQ_TICK: begin
          if (loss_r == LOSS_MAX) begin
            dec_nxt.stick_ch0    = cfg.center_value;
            dec_nxt.stick_ch1    = cfg.center_value;
            dec_nxt.stick_ch2    = cfg.center_value;
            dec_nxt.stick_ch3    = cfg.center_value;
            dec_nxt.switch_left  = cfg.offline_switch;
            dec_nxt.switch_right = cfg.offline_switch;
          end else begin
            loss_nxt = loss_r + 1'b1;
          end
        end
        default: begin
          // unknown request: no change
        end
      endcase
    end
  end

  // Frame store has no reset; entries are defined once written
  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_bytes_r[pos_r[STORE_AW-1:0]] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      loss_r <= '0;
      dec_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      loss_r <= loss_nxt;
      dec_r  <= dec_nxt;
    end
  end

  always_comb begin
    result.stick_ch0      = dec_nxt.stick_ch0;
    result.stick_ch1      = dec_nxt.stick_ch1;
    result.stick_ch2      = dec_nxt.stick_ch2;
    result.stick_ch3      = dec_nxt.stick_ch3;
    result.switch_left    = dec_nxt.switch_left;
    result.switch_right   = dec_nxt.switch_right;
    result.mouse_x        = dec_nxt.mouse_x;
    result.mouse_y        = dec_nxt.mouse_y;
    result.mouse_z        = dec_nxt.mouse_z;
    result.mouse_buttons  = dec_nxt.mouse_buttons;
    result.key_mask       = dec_nxt.key_mask;
    result.reboot_request = dec_nxt.key_mask[KEY_SHIFT_BIT] &
                            dec_nxt.key_mask[KEY_CTRL_BIT] &
                            dec_nxt.key_mask[KEY_B_BIT];
  end

endmodule

// ----- hw/rtl/rcd_out_buf.sv -----
// ----------------------------------------------------------------------------
// rcd_out_buf: output register with skid stage
// Holds results while the receiver stalls; stalls the input only when full.
// ----------------------------------------------------------------------------
module rcd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rcd_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output rcd_pkg::out_item_t out_data
);
  import rcd_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_data_r, main_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      take;

  assign take = main_valid_r & ~out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // no push possible while the skid stage is occupied
      if (take) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

// ----- hw/rtl/rc_receiver_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder: remote-control receiver frame decoder
// Collects received bytes, decodes a frame on line idle, tracks link loss.
// ----------------------------------------------------------------------------
// Each input transaction (received byte, line idle or timer tick) produces
// exactly one result transaction carrying the decoded fields as they stand
// after that request. One transaction is accepted per clock while in_stall
// is low: state update and frame unpacking are a single pass of wiring and
// small muxes, and the result is registered on acceptance. A two-entry output
// buffer (output register plus skid stage) absorbs downstream stalls, so
// in_stall rises only once two results are waiting. Configuration writes
// take effect on the next cycle and are meant for idle periods only.
module rc_receiver_frame_decoder #(
  parameter int BUF_LEN = rcd_pkg::BUF_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rcd_pkg::in_item_t               in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output rcd_pkg::out_item_t              out_data,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rcd_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      accept;
  out_item_t result;
  logic      buf_full;

  // Register file: values masked to their widths, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_LEN:  cfg_nxt.frame_length   = cfg_wdata[5:0];
        CFG_CENTER:     cfg_nxt.center_value   = cfg_wdata[10:0];
        CFG_OFFLINE_SW: cfg_nxt.offline_switch = cfg_wdata[1:0];
        default: begin
          // no register here
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length   <= FRAME_LEN_RST;
      cfg_r.center_value   <= CENTER_RST;
      cfg_r.offline_switch <= OFFLINE_SW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A transaction is taken whenever the skid stage is free
  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  rcd_decode #(
    .BUF_LEN (BUF_LEN)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg_r),
    .result (result)
  );

  rcd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // Skid stage only fills behind an occupied output register
  a_stall_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Every accepted transaction leaves a result waiting
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // Reboot flag tracks the shift, ctrl and B keys of the delivered mask
  a_reboot_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.reboot_request ==
                   (out_data.key_mask[KEY_SHIFT_BIT] &&
                    out_data.key_mask[KEY_CTRL_BIT] &&
                    out_data.key_mask[KEY_B_BIT])))
    else $error("reboot request disagrees with key mask");
`endif

endmodule

// ----- tb/tb_rc_receiver_frame_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_receiver_frame_decoder: self-checking bench for the RC frame decoder
// Sends bytes, line-idle events and timer ticks with random sender gaps and
// receiver stalls. A shadow copy of the decoder state predicts the result of
// every accepted transaction, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_rc_receiver_frame_decoder;
  import rcd_pkg::*;

  localparam int RX_BUF_LEN = BUF_LEN_DEF;
  // request code with no meaning; the block must leave its state alone
  localparam logic [1:0] REQ_NONE = 2'd3;
  // register index with nothing behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // drain margin after the last result, covering the two buffer stages
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // idling percentages, changed between phases
  int tx_gap_pct = 22;
  int rx_stall_pct = 74;

  int mismatch_count = 0;
  int cycle_count = 0;
  int items_sent = 0;

  // shadow of the decoder: registers, byte store, position, loss counter
  cfg_t              shadow_cfg = '{FRAME_LEN_RST, CENTER_RST, OFFLINE_SW_RST};
  logic [7:0]        shadow_bytes [STORE_LEN];
  logic [POS_W-1:0]  shadow_pos = '0;
  logic [LOSS_W-1:0] shadow_loss = '0;
  dec_t              shadow_dec = '0;

  // decoded fields still owed by the block, oldest first
  out_item_t expected_fields_q [$];

  rc_receiver_frame_decoder uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Apply one request to the shadow state and return the fields the block
  // should present afterwards. Every request yields exactly one result.
  function automatic out_item_t predict_decoded_fields(input in_item_t req_item);
    out_item_t fields;
    case (req_item.req_type)
      REQ_BYTE: begin
        // only the first sixteen positions are stored, the rest counted
        if (shadow_pos < POS_W'(STORE_LEN))
          shadow_bytes[shadow_pos[STORE_AW-1:0]] = req_item.rx_byte;
        shadow_pos = (shadow_pos == POS_W'(RX_BUF_LEN - 1)) ? '0 : shadow_pos + 1'b1;
      end
      REQ_IDLE: begin
        shadow_loss = '0;
        if (shadow_pos == shadow_cfg.frame_length) begin
          shadow_dec.stick_ch0    = {shadow_bytes[1][2:0], shadow_bytes[0]};
          shadow_dec.stick_ch1    = {shadow_bytes[2][5:0], shadow_bytes[1][7:3]};
          shadow_dec.stick_ch2    = {shadow_bytes[4][0], shadow_bytes[3],
                                     shadow_bytes[2][7:6]};
          shadow_dec.stick_ch3    = {shadow_bytes[5][3:0], shadow_bytes[4][7:1]};
          shadow_dec.switch_left  = shadow_bytes[5][7:6];
          shadow_dec.switch_right = shadow_bytes[5][5:4];
          shadow_dec.mouse_x       = {shadow_bytes[7], shadow_bytes[6]};
          shadow_dec.mouse_y       = {shadow_bytes[9], shadow_bytes[8]};
          shadow_dec.mouse_z       = {shadow_bytes[11], shadow_bytes[10]};
          shadow_dec.mouse_buttons = {shadow_bytes[13], shadow_bytes[12]};
          shadow_dec.key_mask      = {shadow_bytes[15], shadow_bytes[14]};
        end
        shadow_pos = '0;
      end
      REQ_TICK: begin
        // counter sits at its ceiling; this tick forces the fail-safe
        if (shadow_loss == LOSS_MAX) begin
          shadow_dec.stick_ch0    = shadow_cfg.center_value;
          shadow_dec.stick_ch1    = shadow_cfg.center_value;
          shadow_dec.stick_ch2    = shadow_cfg.center_value;
          shadow_dec.stick_ch3    = shadow_cfg.center_value;
          shadow_dec.switch_left  = shadow_cfg.offline_switch;
          shadow_dec.switch_right = shadow_cfg.offline_switch;
        end else begin
          shadow_loss = shadow_loss + 1'b1;
        end
      end
      default: ;
    endcase
    fields = out_item_t'({shadow_dec, 1'b0});
    fields.reboot_request = shadow_dec.key_mask[KEY_SHIFT_BIT] &
                            shadow_dec.key_mask[KEY_CTRL_BIT] &
                            shadow_dec.key_mask[KEY_B_BIT];
    return fields;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fields_q.size() == 0) begin
        $error("unexpected result transaction, nothing outstanding");
        mismatch_count++;
      end else begin
        want = expected_fields_q.pop_front();
        check_field("stick_ch0", int'(want.stick_ch0), int'(out_data.stick_ch0));
        check_field("stick_ch1", int'(want.stick_ch1), int'(out_data.stick_ch1));
        check_field("stick_ch2", int'(want.stick_ch2), int'(out_data.stick_ch2));
        check_field("stick_ch3", int'(want.stick_ch3), int'(out_data.stick_ch3));
        check_field("switch_left", int'(want.switch_left), int'(out_data.switch_left));
        check_field("switch_right", int'(want.switch_right),
                    int'(out_data.switch_right));
        check_field("mouse_x", int'(want.mouse_x), int'(out_data.mouse_x));
        check_field("mouse_y", int'(want.mouse_y), int'(out_data.mouse_y));
        check_field("mouse_z", int'(want.mouse_z), int'(out_data.mouse_z));
        check_field("mouse_buttons", int'(want.mouse_buttons),
                    int'(out_data.mouse_buttons));
        check_field("key_mask", int'(want.key_mask), int'(out_data.key_mask));
        check_field("reboot_request", int'(want.reboot_request),
                    int'(out_data.reboot_request));
      end
    end
  end

  // One input transaction. Drives at the falling edge, with random gaps, and
  // holds valid and payload until the block takes it at a rising edge. Valid
  // stays high on return so back-to-back requests need no extra step.
  task automatic send_request(input logic [1:0] req, input logic [7:0] data);
    in_item_t req_item;
    req_item.req_type = req;
    req_item.rx_byte  = data;
    @(negedge clk);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req_item;
    do @(posedge clk); while (in_stall);
    expected_fields_q.push_back(predict_decoded_fields(req_item));
    if (req != REQ_NONE) items_sent++;
  endtask

  // Random frame bytes; the key-mask bytes often carry the reboot keys.
  task automatic send_frame_bytes(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom_range(255));
      if (i == 14 && $urandom_range(2) == 0) begin
        b[KEY_SHIFT_BIT] = 1'b1;
        b[KEY_CTRL_BIT]  = 1'b1;
      end
      if (i == 15 && $urandom_range(2) == 0) b[KEY_B_BIT - 8] = 1'b1;
      send_request(REQ_BYTE, b);
    end
  endtask

  // Drop valid and let every owed result come out; ends on a falling edge.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_fields_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write, only ever with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_LEN:  shadow_cfg.frame_length   = value[5:0];
      CFG_CENTER:     shadow_cfg.center_value   = value;
      CFG_OFFLINE_SW: shadow_cfg.offline_switch = value[1:0];
      default: ;
    endcase
  endtask

  // First frame: fills all sixteen stored bytes before any decode, with
  // field extremes (full-scale stick, mouse min/max/-1, reboot keys held).
  task automatic test_frame_decode();
    logic [7:0] pattern [STORE_LEN] = '{8'hFF, 8'h07, 8'h00, 8'hFF,
                                        8'h00, 8'hC0, 8'h00, 8'h80,
                                        8'hFF, 8'h7F, 8'hFF, 8'hFF,
                                        8'h00, 8'hFF, 8'h30, 8'h80};
    write_reg(CFG_FRAME_LEN, 11'd16);
    for (int i = 0; i < STORE_LEN; i++) send_request(REQ_BYTE, pattern[i]);
    send_request(REQ_IDLE, 8'h00);
  endtask

  // Unknown request, a few ticks, register masking, the dead index, an empty
  // frame with a zero length and a length the position can never reach.
  task automatic test_request_corners();
    send_request(REQ_NONE, 8'hA5);
    send_request(REQ_TICK, 8'h5A);
    send_request(REQ_TICK, 8'hFF);
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_OFFLINE_SW, 11'h7FF);
    write_reg(CFG_CENTER, 11'd2047);
    write_reg(CFG_FRAME_LEN, 11'h7C0);
    send_request(REQ_IDLE, 8'h00);
    write_reg(CFG_FRAME_LEN, 11'd63);
    send_frame_bytes(3);
    send_request(REQ_IDLE, 8'hFF);
  endtask

  // Mostly well-formed frames with random content; the rest is tick runs
  // long enough to trip link loss, wrong lengths, wrapped frames and noise.
  task automatic test_random_traffic(input int n, input int gap_pct, input int stall_pct,
                                     input logic [CFG_DATA_W-1:0] frame_len,
                                     input logic [CFG_DATA_W-1:0] center,
                                     input logic [CFG_DATA_W-1:0] offline);
    int stop_at;
    int pick;
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    write_reg(CFG_FRAME_LEN, frame_len);
    write_reg(CFG_CENTER, center);
    write_reg(CFG_OFFLINE_SW, offline);
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame_bytes(int'(shadow_cfg.frame_length));
        send_request(REQ_IDLE, 8'($urandom_range(255)));
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 20)) send_request(REQ_TICK, 8'($urandom_range(255)));
      end else if (pick < 82) begin
        send_frame_bytes($urandom_range(int'(shadow_cfg.frame_length) + 3));
        send_request(REQ_IDLE, 8'($urandom_range(255)));
      end else if (pick < 90) begin
        // position comes round once and lands on the frame length again
        send_frame_bytes(RX_BUF_LEN + int'(shadow_cfg.frame_length));
        send_request(REQ_IDLE, 8'($urandom_range(255)));
      end else begin
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_frame_decode();
    test_request_corners();
    test_random_traffic(260, 22, 74, 11'd18, 11'd2047, 11'd3);
    test_random_traffic(260, 74, 22, 11'd1, 11'd0, 11'd1);
    test_random_traffic(260, 0, 0, 11'd35, 11'd1024, 11'd2);

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
